>>> sv/assert_macros.svh
// Assertion helpers for the RTL, included by the sorted key table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

>>> sv/skl_pkg.sv
`default_nettype none

package skl_pkg;

   // Field widths
   localparam int KEY_W   = 16;
   localparam int ACT_W   = 2;
   localparam int STAT_W  = 2;

   // Default table depth
   localparam int DEPTH_DEFAULT = 16;

   // Request action codes
   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LIST   = 2'd2;

   // Response status codes
   localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

endpackage

`default_nettype wire

>>> sv/skl_ram.sv
`default_nettype none

module skl_ram import skl_pkg::*; #(
   parameter int WIDTH = KEY_W,
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

>>> sv/sorted_key_list_insert_remove.sv
// Sorted key table in a RAM; one request at a time, the next taken in the cycle after its last beat.
// Insert: result in the cycle after accept when full or empty, else the words above the insert point move up
//   (one RAM entry shifted per cycle from the top down to the insert point), then the key is written.
// Remove: result in the cycle after accept when empty, else scan then shift, one RAM entry per cycle.
// List: per key, a RAM read into the output register, then an output beat held until taken.
// Reset clears the sequencer state and the key count only; the key store keeps its contents, no clearing pass.
`default_nettype none

module sorted_key_list_insert_remove import skl_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [ACT_W-1:0]  req_action,
   input  wire logic [KEY_W-1:0]  req_key,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [STAT_W-1:0] rsp_status,
   output logic      [KEY_W-1:0]  rsp_entry_key,
   output logic                   rsp_last,
   output logic      [CW-1:0]     rsp_entry_count
);

   `include "assert_macros.svh"

   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [AW-1:0] ONE_A    = AW'(1);
   localparam logic [AW-1:0] TWO_A    = AW'(2);

   // Sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INS      = 3'd1;
   localparam logic [2:0] S_INS_PUT  = 3'd2;
   localparam logic [2:0] S_RM_SCAN  = 3'd3;
   localparam logic [2:0] S_RM_SHIFT = 3'd4;
   localparam logic [2:0] S_LIST_LD  = 3'd5;
   localparam logic [2:0] S_RESP     = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [KEY_W-1:0]  out_key_ff, out_key_in;
   logic              last_ff, last_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [KEY_W-1:0]  ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [KEY_W-1:0]  ram_rdata;

   logic              req_fire;
   logic              rsp_fire;
   logic              key_le;
   logic              key_eq;
   logic              ptr_at_end;

   skl_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_RESP);
   assign req_fire        = req_valid && !req_stall;
   assign rsp_fire        = rsp_valid && !rsp_stall;
   assign rsp_status      = status_ff;
   assign rsp_entry_key   = out_key_ff;
   assign rsp_last        = last_ff;
   assign rsp_entry_count = count_ff;

   // Shared compare unit: stored word against the request key
   assign key_le     = (ram_rdata <= key_ff);
   assign key_eq     = (ram_rdata == key_ff);
   assign ptr_at_end = ((CW'(ptr_ff) + CW'(1)) == count_ff);

   // Sequence one request through the store
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      key_in     = key_ff;
      status_in  = status_ff;
      out_key_in = out_key_ff;
      last_in    = last_ff;
      ram_we     = 1'b0;
      ram_waddr  = ptr_ff;
      ram_wdata  = key_ff;
      ram_raddr  = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in     = req_key;
               out_key_in = req_key;
               status_in  = STAT_DONE;
               last_in    = 1'b1;
               unique case (req_action)
                  ACT_INSERT: begin
                     if (count_ff == FULL_CNT) begin
                        status_in = STAT_FULL;
                        state_in  = S_RESP;
                     end else if (count_ff == '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = req_key;
                        count_in  = count_ff + CW'(1);
                        state_in  = S_RESP;
                     end else begin
                        ptr_in    = count_ff[AW-1:0];
                        ram_raddr = count_ff[AW-1:0] - ONE_A;
                        state_in  = S_INS;
                     end
                  end
                  ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_NOTFOUND;
                        state_in  = S_RESP;
                     end else begin
                        ptr_in    = '0;
                        ram_raddr = '0;
                        state_in  = S_RM_SCAN;
                     end
                  end
                  ACT_LIST: begin
                     if (count_ff == '0) begin
                        status_in  = STAT_EMPTY;
                        out_key_in = '0;
                        state_in   = S_RESP;
                     end else begin
                        ptr_in    = '0;
                        ram_raddr = '0;
                        state_in  = S_LIST_LD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Data at ptr-1 is on the read port; drop key in or move word up
         S_INS: begin
            ram_we = 1'b1;
            if (key_le) begin
               ram_wdata = key_ff;
               count_in  = count_ff + CW'(1);
               state_in  = S_RESP;
            end else begin
               ram_wdata = ram_rdata;
               ptr_in    = ptr_ff - ONE_A;
               if (ptr_ff == ONE_A) begin
                  state_in = S_INS_PUT;
               end else begin
                  ram_raddr = ptr_ff - TWO_A;
               end
            end
         end

         // Every stored word was larger: key goes to the bottom
         S_INS_PUT: begin
            ram_we    = 1'b1;
            ram_wdata = key_ff;
            count_in  = count_ff + CW'(1);
            state_in  = S_RESP;
         end

         // Search upward for the first equal word
         S_RM_SCAN: begin
            if (key_eq) begin
               if (ptr_at_end) begin
                  count_in = count_ff - CW'(1);
                  state_in = S_RESP;
               end else begin
                  ptr_in    = ptr_ff + ONE_A;
                  ram_raddr = ptr_ff + ONE_A;
                  state_in  = S_RM_SHIFT;
               end
            end else if (ptr_at_end) begin
               status_in = STAT_NOTFOUND;
               state_in  = S_RESP;
            end else begin
               ptr_in    = ptr_ff + ONE_A;
               ram_raddr = ptr_ff + ONE_A;
            end
         end

         // Move each word above the hole down by one
         S_RM_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff - ONE_A;
            ram_wdata = ram_rdata;
            if (ptr_at_end) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end else begin
               ptr_in    = ptr_ff + ONE_A;
               ram_raddr = ptr_ff + ONE_A;
            end
         end

         // Load one listed key into the output register
         S_LIST_LD: begin
            out_key_in = ram_rdata;
            status_in  = STAT_DONE;
            last_in    = ptr_at_end;
            state_in   = S_RESP;
         end

         // Hold the beat until taken; fetch the next listed key
         S_RESP: begin
            if (rsp_fire) begin
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in    = ptr_ff + ONE_A;
                  ram_raddr = ptr_ff + ONE_A;
                  state_in  = S_LIST_LD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      out_key_ff <= out_key_in;
      last_ff    <= last_in;
   end

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > FULL_CNT, "key count above depth")
   `ASSERT_PROP(a_rsp_blocks_req, clock, reset, rsp_valid |-> req_stall, "request taken during response")
   `ASSERT_PROP(a_write_in_update, clock, reset, (ram_we && state_ff != S_IDLE) |-> (state_ff == S_INS || state_ff == S_INS_PUT || state_ff == S_RM_SHIFT), "store written outside update")
   `ASSERT_PROP(a_count_step, clock, reset, (count_ff != $past(count_ff)) |-> (state_ff == S_RESP), "count changed without a result")

endmodule

`default_nettype wire

>>> verif/key_table_check_pkg.sv
`default_nettype none

package key_table_check_pkg;
   import skl_pkg::*;

   localparam int TABLE_DEPTH = DEPTH_DEFAULT;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   // Code the block accepts and ignores
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [KEY_W-1:0]   entry_key;
      logic               last;
      logic [COUNT_W-1:0] entry_count;
   } table_result_type;

   // Mirrors the sorted table and holds the result beats still owed by the block
   class key_table_checker_type;
      logic [KEY_W-1:0] held_keys[$];
      table_result_type awaited[$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int unsigned held_count();
         return held_keys.size();
      endfunction

      function logic [KEY_W-1:0] held_key(int unsigned idx);
         return held_keys[idx];
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function void add_awaited(logic [STAT_W-1:0] status, logic [KEY_W-1:0] k,
                                logic last, int unsigned count);
         table_result_type r;
         r.status      = status;
         r.entry_key   = k;
         r.last        = last;
         r.entry_count = COUNT_W'(count);
         awaited.insert(awaited.size(), r);
      endfunction

      // Apply one accepted request to the table and queue its result beats
      function void note_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k);
         int unsigned n;
         int unsigned pos;
         n   = held_keys.size();
         pos = 0;
         case (act)
            ACT_INSERT: begin
               if (n >= TABLE_DEPTH) begin
                  add_awaited(STAT_FULL, k, 1'b1, n);
               end else begin
                  // place after every key less than or equal to it
                  while (pos < n && held_keys[pos] <= k) pos++;
                  held_keys.insert(pos, k);
                  add_awaited(STAT_DONE, k, 1'b1, n + 1);
               end
            end
            ACT_REMOVE: begin
               // drop the first equal key only
               while (pos < n && held_keys[pos] != k) pos++;
               if (pos >= n) begin
                  add_awaited(STAT_NOTFOUND, k, 1'b1, n);
               end else begin
                  held_keys.delete(pos);
                  add_awaited(STAT_DONE, k, 1'b1, n - 1);
               end
            end
            ACT_LIST: begin
               if (n == 0) begin
                  add_awaited(STAT_EMPTY, '0, 1'b1, 0);
               end else begin
                  foreach (held_keys[i]) add_awaited(STAT_DONE, held_keys[i], i == n - 1, n);
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string field, logic [KEY_W-1:0] want_v,
                                  logic [KEY_W-1:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want_v, got_v);
            mismatches++;
         end
      endfunction

      // Match one accepted result beat against the oldest one owed
      function void check_beat(logic [STAT_W-1:0] status, logic [KEY_W-1:0] k,
                               logic last, logic [COUNT_W-1:0] count);
         table_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result beat with nothing awaited: expected none, actual %h %h %b %h",
                     $time, status, k, last, count);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         compare_field("status", KEY_W'(want.status), KEY_W'(status));
         compare_field("entry_key", want.entry_key, k);
         compare_field("last", KEY_W'(want.last), KEY_W'(last));
         compare_field("entry_count", KEY_W'(want.entry_count), KEY_W'(count));
      endfunction
   endclass

endpackage

`default_nettype wire

>>> verif/tb_sorted_key_list_insert_remove.sv
`default_nettype none

module tb_sorted_key_list_insert_remove import skl_pkg::*, key_table_check_pkg::*;;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 136;
   localparam int TAIL_CYCLES  = 64;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [ACT_W-1:0]   req_action = ACT_INSERT;
   logic [KEY_W-1:0]   req_key = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [STAT_W-1:0]  rsp_status;
   logic [KEY_W-1:0]   rsp_entry_key;
   logic               rsp_last;
   logic [COUNT_W-1:0] rsp_entry_count;

   key_table_checker_type tracker;
   int unsigned           idle_cycles = 0;
   int unsigned           stall_left = 0;
   logic [1:0]            stall_mode = 2'd0;

   sorted_key_list_insert_remove #(.DEPTH(TABLE_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_key   (rsp_entry_key),
      .rsp_last        (rsp_last),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Track accepted beats on both channels and count quiet cycles
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) tracker.note_request(req_action, req_key);
         if (rsp_valid && !rsp_stall)
            tracker.check_beat(rsp_status, rsp_entry_key, rsp_last, rsp_entry_count);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Stall results: free-flowing, random, or periodic runs, with a new mode picked when each run ends
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 2));
            stall_left <= $urandom_range(20, 80);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            2'd0:    rsp_stall <= 1'b0;
            2'd1:    rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= stall_left[3];
         endcase
      end
   end

   // Hold one request until the block takes it
   task automatic send_beat(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k);
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= k;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every owed result beat has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // Four in ten from a small pool so duplicates and removal hits are common
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return KEY_W'($urandom_range(0, 7) << 12);
      if (roll == 4) return ($urandom_range(0, 1) == 1) ? '1 : '0;
      return KEY_W'($urandom());
   endfunction

   function automatic logic [KEY_W-1:0] pick_removal_key();
      int unsigned n;
      n = tracker.held_count();
      if (n > 0 && $urandom_range(0, 99) < 65) return tracker.held_key($urandom_range(0, n - 1));
      return pick_key();
   endfunction

   // Alternate fill, mixed and drain phases so the table swings between empty and full
   function automatic logic [ACT_W-1:0] pick_action(int unsigned n);
      int unsigned roll;
      int unsigned insert_pct;
      roll = $urandom_range(0, 99);
      case ((n / 40) % 4)
         0:       insert_pct = 70;
         2:       insert_pct = 20;
         default: insert_pct = 45;
      endcase
      if (roll < 3) return ACT_UNUSED;
      if (roll < 18) return ACT_LIST;
      if (roll < 18 + insert_pct) return ACT_INSERT;
      return ACT_REMOVE;
   endfunction

   initial begin
      int unsigned      sent;
      int unsigned      burst_left;
      int unsigned      gap;
      bit               paused;
      logic [ACT_W-1:0] act;
      logic [KEY_W-1:0] k;

      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table cases and an ignored code
      send_beat(ACT_LIST, '0);
      send_beat(ACT_REMOVE, 16'h0005);
      send_beat(ACT_UNUSED, 16'hA5A5);
      // extremes and a duplicate, then fill to capacity
      send_beat(ACT_INSERT, 16'hFFFF);
      send_beat(ACT_INSERT, 16'h0000);
      send_beat(ACT_INSERT, 16'h8000);
      send_beat(ACT_INSERT, 16'h8000);
      send_beat(ACT_INSERT, 16'h7FFF);
      for (int i = 0; i < 11; i++) send_beat(ACT_INSERT, KEY_W'(16'h9000 - i * 16'h0C31));
      // full table, full listing, removals at both ends, a duplicate and an absent key
      send_beat(ACT_INSERT, 16'h4242);
      send_beat(ACT_LIST, '0);
      send_beat(ACT_REMOVE, 16'h0000);
      send_beat(ACT_REMOVE, 16'hFFFF);
      send_beat(ACT_REMOVE, 16'h8000);
      send_beat(ACT_REMOVE, 16'h1234);
      drain_results();

      // random traffic in bursts with gaps
      sent       = 0;
      burst_left = 0;
      paused     = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 12);
         end
         act = pick_action(sent);
         k   = (act == ACT_REMOVE) ? pick_removal_key() : pick_key();
         send_beat(act, k);
         burst_left--;
         if (act != ACT_UNUSED) sent++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // End a hung run
   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
